@@ rtl/itrd_pkg.sv @@
// itrd_pkg: shared types, constants and the digit-to-ascii function
// for the integer to radix digits converter; depends on nothing

package itrd_pkg;

  // quotient bits resolved per cycle by the shared divider
  localparam int DIV_STEP_BITS = 4;

  localparam logic [5:0] RADIX_MIN = 6'd2;
  localparam logic [5:0] RADIX_MAX = 6'd36;
  localparam logic [5:0] DEC_DIGITS = 6'd10;

  localparam logic [6:0] ASCII_ZERO = 7'h30;
  localparam logic [6:0] ASCII_NINE = 7'h39;
  localparam logic [6:0] ASCII_A = 7'h41;
  localparam logic [6:0] ASCII_Z = 7'h5A;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV_GO,
    S_DIV_WAIT,
    S_READ,
    S_SHOW
  } state_t;

  function automatic logic [6:0] digit_to_ascii(input logic [5:0] d);
    logic [6:0] res;
    if (d < DEC_DIGITS) begin
      res = ASCII_ZERO + {1'b0, d};
    end else begin
      res = ASCII_A + {1'b0, d} - {1'b0, DEC_DIGITS};
    end
    return res;
  endfunction

endpackage

@@ rtl/itrd_if.sv @@
// itrd_in_if / itrd_out_if: valid-ready channels of the converter
// depends on nothing

interface itrd_in_if #(
  parameter int VALUE_BITS = 31
);
  logic                  valid;
  logic                  ready;
  logic [VALUE_BITS-1:0] value;
  logic [5:0]            radix;

  modport source (output valid, output value, output radix, input ready);
  modport sink (input valid, input value, input radix, output ready);
endinterface

interface itrd_out_if;
  logic       valid;
  logic       ready;
  logic [6:0] digit_char;
  logic       has_digit;
  logic       last;

  modport source (output valid, output digit_char, output has_digit, output last, input ready);
  modport sink (input valid, input digit_char, input has_digit, input last, output ready);
endinterface

@@ rtl/integer_to_radix_digits.sv @@
// integer_to_radix_digits: converts an unsigned integer into ascii digits of
// a radix from 2 to 36, most significant digit first, last digit marked.
// One word is taken, then the block is busy until its last digit has gone
// out. Each digit costs one pass of the shared divider, which resolves four
// quotient bits a cycle; the block then reads the remainder memory and hands
// out each digit in turn. The radix is clamped into 2..36. If a value has
// more than MAX_DIGITS digits, only the low MAX_DIGITS digits are produced.
// Depends on itrd_pkg, the channel interfaces, itrd_divider and
// itrd_digit_store.

module integer_to_radix_digits #(
  parameter int VALUE_BITS = 31,
  parameter int MAX_DIGITS = 32
) (
  input logic        clk,
  input logic        rst_n,
  itrd_in_if.sink    in_ch,
  itrd_out_if.source out_ch
);

  localparam int IDX_W = $clog2(MAX_DIGITS);
  localparam int CNT_W = $clog2(MAX_DIGITS + 1);

  // sequencer state and working registers
  itrd_pkg::state_t      state_r, state_nxt;
  logic [VALUE_BITS-1:0] quot_r, quot_nxt;   // running quotient
  logic [5:0]            radix_r, radix_nxt; // clamped radix
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;     // digits produced so far
  logic [IDX_W-1:0]      rd_idx_r, rd_idx_nxt;
  logic                  zero_r, zero_nxt;   // zero value: no digit

  // divider and memory hookup
  logic                  div_start;
  logic                  div_done;
  logic [VALUE_BITS-1:0] div_quot;
  logic [5:0]            div_rem;
  logic                  st_wr_en;
  logic [5:0]            st_rd_data;

  assign div_start = (state_r == itrd_pkg::S_DIV_GO);
  assign st_wr_en  = (state_r == itrd_pkg::S_DIV_WAIT) && div_done;

  itrd_divider #(
    .VALUE_BITS(VALUE_BITS)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (quot_r),
    .divisor  (radix_r),
    .done     (div_done),
    .quotient (div_quot),
    .remainder(div_rem)
  );

  // remainders land least significant first, read back in reverse
  itrd_digit_store #(
    .MAX_DIGITS(MAX_DIGITS)
  ) u_store (
    .clk    (clk),
    .wr_en  (st_wr_en),
    .wr_addr(cnt_r[IDX_W-1:0]),
    .wr_data(div_rem),
    .rd_addr(rd_idx_r),
    .rd_data(st_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= itrd_pkg::S_IDLE;
      quot_r  <= '0;
      cnt_r   <= '0;
      zero_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      quot_r  <= quot_nxt;
      cnt_r   <= cnt_nxt;
      zero_r  <= zero_nxt;
    end
  end

  always_ff @(posedge clk) begin
    radix_r  <= radix_nxt;
    rd_idx_r <= rd_idx_nxt;
  end

  // final word: the zero case or the least significant digit
  logic show_last;
  assign show_last = zero_r || (rd_idx_r == '0);

  always_comb begin
    state_nxt  = state_r;
    quot_nxt   = quot_r;
    radix_nxt  = radix_r;
    cnt_nxt    = cnt_r;
    rd_idx_nxt = rd_idx_r;
    zero_nxt   = zero_r;

    in_ch.ready       = 1'b0;
    out_ch.valid      = 1'b0;
    out_ch.has_digit  = !zero_r;
    out_ch.digit_char = zero_r ? 7'd0 : itrd_pkg::digit_to_ascii(st_rd_data);
    out_ch.last       = show_last;

    case (state_r)
      itrd_pkg::S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_ch.valid) begin
          quot_nxt = in_ch.value;
          cnt_nxt  = '0;
          if (in_ch.radix < itrd_pkg::RADIX_MIN) begin
            radix_nxt = itrd_pkg::RADIX_MIN;
          end else if (in_ch.radix > itrd_pkg::RADIX_MAX) begin
            radix_nxt = itrd_pkg::RADIX_MAX;
          end else begin
            radix_nxt = in_ch.radix;
          end
          if (in_ch.value == '0) begin
            zero_nxt  = 1'b1;
            state_nxt = itrd_pkg::S_SHOW;
          end else begin
            zero_nxt  = 1'b0;
            state_nxt = itrd_pkg::S_DIV_GO;
          end
        end
      end
      itrd_pkg::S_DIV_GO: begin
        state_nxt = itrd_pkg::S_DIV_WAIT;
      end
      itrd_pkg::S_DIV_WAIT: begin
        if (div_done) begin
          quot_nxt = div_quot;
          cnt_nxt  = cnt_r + CNT_W'(1);
          // stop when the quotient runs out or the store is full
          if (div_quot == '0 || cnt_r == CNT_W'(MAX_DIGITS - 1)) begin
            rd_idx_nxt = cnt_r[IDX_W-1:0];
            state_nxt  = itrd_pkg::S_READ;
          end else begin
            state_nxt = itrd_pkg::S_DIV_GO;
          end
        end
      end
      itrd_pkg::S_READ: begin
        state_nxt = itrd_pkg::S_SHOW;
      end
      itrd_pkg::S_SHOW: begin
        out_ch.valid = 1'b1;
        if (out_ch.ready) begin
          if (show_last) begin
            quot_nxt  = '0;
            zero_nxt  = 1'b0;
            state_nxt = itrd_pkg::S_IDLE;
          end else begin
            rd_idx_nxt = rd_idx_r - IDX_W'(1);
            state_nxt  = itrd_pkg::S_READ;
          end
        end
      end
      default: begin
        state_nxt = itrd_pkg::S_IDLE;
      end
    endcase
  end

endmodule

@@ rtl/itrd_divider.sv @@
// itrd_divider: iterative restoring divider by a 6-bit radix,
// DIV_STEP_BITS quotient bits per cycle; depends on itrd_pkg

module itrd_divider #(
  parameter int VALUE_BITS = 31
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [VALUE_BITS-1:0] dividend,
  input  logic [5:0]            divisor,
  output logic                  done,
  output logic [VALUE_BITS-1:0] quotient,
  output logic [5:0]            remainder
);

  localparam int SB    = itrd_pkg::DIV_STEP_BITS;
  localparam int STEPS = (VALUE_BITS + SB - 1) / SB;
  localparam int PAD_W = STEPS * SB;
  localparam int CNT_W = $clog2(STEPS + 1);

  logic [PAD_W-1:0] q_r;
  logic [5:0]       rem_r;
  logic [CNT_W-1:0] cnt_r;
  logic             busy_r;
  logic             done_r;

  logic [6:0]       rem_w;
  logic [SB-1:0]    qbits;

  // shift-compare-subtract steps, one per quotient bit, on the narrow partial remainder
  always_comb begin
    rem_w = {1'b0, rem_r};
    qbits = '0;
    for (int i = 0; i < SB; i++) begin
      rem_w = {rem_w[5:0], q_r[PAD_W-1-i]};
      if (rem_w >= {1'b0, divisor}) begin
        rem_w = rem_w - {1'b0, divisor};
        qbits[SB-1-i] = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start && !busy_r) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(STEPS);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy_r) begin
      q_r   <= PAD_W'(dividend);
      rem_r <= '0;
    end else if (busy_r) begin
      q_r   <= {q_r[PAD_W-SB-1:0], qbits};
      rem_r <= rem_w[5:0];
    end
  end

  assign done      = done_r;
  assign quotient  = q_r[VALUE_BITS-1:0];
  assign remainder = rem_r;

endmodule

@@ rtl/itrd_digit_store.sv @@
// itrd_digit_store: remainder memory, one write port and one
// registered read port; depends on nothing

module itrd_digit_store #(
  parameter int MAX_DIGITS = 32
) (
  input  logic                          clk,
  input  logic                          wr_en,
  input  logic [$clog2(MAX_DIGITS)-1:0] wr_addr,
  input  logic [5:0]                    wr_data,
  input  logic [$clog2(MAX_DIGITS)-1:0] rd_addr,
  output logic [5:0]                    rd_data
);

  logic [5:0] mem [MAX_DIGITS];
  logic [5:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

@@ rtl/itrd_checker.sv @@
// itrd_checker: port-level assertions for integer_to_radix_digits and
// the bind that attaches them; depends on itrd_pkg

module itrd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [6:0] out_digit_char,
  input logic       out_has_digit,
  input logic       out_last
);

  // after reset the block waits for a word and shows nothing
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> in_ready && !out_valid)
    else $error("not idle after reset");

  // one conversion at a time: no intake while a digit is on show
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input ready while output word pending");

  // a word without a digit is the whole answer for a zero value
  a_zero_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_has_digit |-> out_last && out_digit_char == 7'd0)
    else $error("digitless word not marked last");

  a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_has_digit |->
      (out_digit_char >= itrd_pkg::ASCII_ZERO && out_digit_char <= itrd_pkg::ASCII_NINE) ||
      (out_digit_char >= itrd_pkg::ASCII_A && out_digit_char <= itrd_pkg::ASCII_Z))
    else $error("digit character out of range");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=>
      out_valid && $stable(out_digit_char) && $stable(out_has_digit) && $stable(out_last))
    else $error("stalled output word changed");

endmodule

bind integer_to_radix_digits itrd_checker u_itrd_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_digit_char(out_ch.digit_char),
  .out_has_digit (out_ch.has_digit),
  .out_last      (out_ch.last)
);

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps
// testbench: self-checking bench for integer_to_radix_digits, a directed table then random words
// depends on itrd_pkg, itrd_in_if / itrd_out_if and the integer_to_radix_digits rtl

module testbench;

  localparam int VALUE_BITS = 31;
  localparam int MAX_DIGITS = 32;

  localparam int RESET_CYCLES  = 9;
  localparam int RANDOM_WORDS  = 290;
  localparam int PAUSE_AT      = 60;      // random word before which the sender drains the block
  localparam int CALM_FIRST    = 200;     // stretch of random words with no idling on either side
  localparam int CALM_LAST     = 240;
  localparam int HOLD_AFTER    = 600;     // results seen before the long receiver hold
  localparam int LONG_HOLD     = 400;     // cycles the receiver keeps ready low
  localparam int DRAIN_CYCLES  = 64;
  localparam int CYCLE_LIMIT   = 1000000;
  localparam int SHOWN_FAULTS  = 10;

  localparam logic [6:0] CHAR_ZERO = 7'h30;
  localparam logic [6:0] CHAR_A    = 7'h41;
  localparam logic [5:0] TEN       = 6'd10;

  // one result word as it leaves the block
  typedef struct packed {
    logic [6:0] digit_char;
    logic       has_digit;
    logic       last;
  } digit_word_t;

  // directed row: typed rows carry the digit string to expect, empty for a zero value
  typedef struct {
    logic [VALUE_BITS-1:0] value;
    logic [5:0]            radix;
    bit                    typed;
    string                 text;
  } directed_row_t;

  localparam int DIRECTED_ROWS = 21;

  directed_row_t directed_rows [DIRECTED_ROWS] = '{
    // zero right after reset: one word with no digit
    '{31'd0,          6'd10, 1'b1, ""},
    '{31'd1,          6'd2,  1'b1, "1"},
    // largest value in the extreme and common bases
    '{31'h7FFF_FFFF,  6'd2,  1'b1, {"1111111111", "1111111111", "1111111111", "1"}},
    '{31'h7FFF_FFFF,  6'd8,  1'b1, "17777777777"},
    '{31'h7FFF_FFFF,  6'd10, 1'b1, "2147483647"},
    '{31'h7FFF_FFFF,  6'd16, 1'b1, "7FFFFFFF"},
    '{31'h7FFF_FFFF,  6'd36, 1'b0, ""},
    // top symbol and the first carry in base 36
    '{31'd35,         6'd36, 1'b1, "Z"},
    '{31'd36,         6'd36, 1'b1, "10"},
    '{31'd1295,       6'd36, 1'b1, "ZZ"},
    // boundary between decimal and letter symbols
    '{31'd9,          6'd10, 1'b1, "9"},
    '{31'd10,         6'd11, 1'b1, "A"},
    // radix below two saturates to binary
    '{31'd5,          6'd0,  1'b1, "101"},
    '{31'd5,          6'd1,  1'b1, "101"},
    // radix above thirty-six saturates to base 36
    '{31'd35,         6'd37, 1'b1, "Z"},
    '{31'd36,         6'd63, 1'b1, "10"},
    '{31'd0,          6'd63, 1'b1, ""},
    '{31'd0,          6'd0,  1'b1, ""},
    // single high bit and alternating bit patterns
    '{31'h4000_0000,  6'd2,  1'b0, ""},
    '{31'h2AAA_AAAA,  6'd3,  1'b0, ""},
    '{31'h5555_5555,  6'd35, 1'b0, ""}
  };

  logic clk;
  logic rst_n;

  itrd_in_if #(.VALUE_BITS(VALUE_BITS)) in_ch ();
  itrd_out_if out_ch ();

  integer_to_radix_digits #(
    .VALUE_BITS(VALUE_BITS),
    .MAX_DIGITS(MAX_DIGITS)
  ) u_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch)
  );

  // expected result words, oldest first
  digit_word_t digits_due[$];

  int  mismatch_count = 0;
  int  results_seen   = 0;
  int  cycle_count    = 0;
  bit  calm           = 1'b0;
  bit  long_hold_done = 1'b0;

  // what the sender is offering right now: typed row or predictor row
  bit    row_typed = 1'b0;
  string row_text  = "";

  // 12 ns clock
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // count a failure, show only the first few
  function automatic void log_fault(input string msg);
    mismatch_count++;
    if (mismatch_count <= SHOWN_FAULTS) $display("%s", msg);
  endfunction

  // radix conversion: repeated division, remainders kept lsd first, queued msd first
  function automatic void predict_digits(input logic [VALUE_BITS-1:0] value,
                                         input logic [5:0] radix);
    logic [5:0]            base;
    logic [VALUE_BITS-1:0] quot;
    logic [5:0]            rems [MAX_DIGITS];
    logic [5:0]            d;
    int                    n;
    digit_word_t           w;
    base = (radix < itrd_pkg::RADIX_MIN) ? itrd_pkg::RADIX_MIN :
           (radix > itrd_pkg::RADIX_MAX) ? itrd_pkg::RADIX_MAX : radix;
    quot = value;
    n = 0;
    while (quot != '0 && n < MAX_DIGITS) begin
      rems[n] = 6'(quot % base);
      quot = quot / base;
      n++;
    end
    if (n == 0) begin
      // zero value: a single word without a digit
      w = '{digit_char: 7'd0, has_digit: 1'b0, last: 1'b1};
      digits_due.push_back(w);
    end else begin
      for (int k = 0; k < n; k++) begin
        d = rems[n - 1 - k];
        w.digit_char = (d < TEN) ? CHAR_ZERO + 7'(d) : CHAR_A + 7'(d) - 7'(TEN);
        w.has_digit  = 1'b1;
        w.last       = (k == n - 1);
        digits_due.push_back(w);
      end
    end
  endfunction

  // drive one input word after a random gap, return once it is taken
  task automatic offer_word(input logic [VALUE_BITS-1:0] value, input logic [5:0] radix,
                            input bit typed, input string text);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid <= 1'b0;
    end
    @(negedge clk);
    in_ch.valid <= 1'b1;
    in_ch.value <= value;
    in_ch.radix <= radix;
    row_typed = typed;
    row_text  = text;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
  endtask

  // sender: reset, directed table, then random words
  initial begin : stimulus
    logic [VALUE_BITS-1:0] v;
    logic [5:0]            r;
    int                    span;
    rst_n       = 1'b0;
    in_ch.valid = 1'b0;
    in_ch.value = '0;
    in_ch.radix = '0;
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i])
      offer_word(directed_rows[i].value, directed_rows[i].radix,
                 directed_rows[i].typed, directed_rows[i].text);

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      calm = (i >= CALM_FIRST && i < CALM_LAST);
      // let the block run dry once before going on
      if (i == PAUSE_AT) begin
        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (digits_due.size() != 0) @(negedge clk);
      end
      // random bit length spreads digit counts from none up to the full width
      span = $urandom_range(0, VALUE_BITS);
      v = VALUE_BITS'(64'($urandom) & ((64'd1 << span) - 64'd1));
      // mostly legal bases, sometimes any 6-bit code to hit the saturation
      if ($urandom_range(0, 9) < 8) r = 6'($urandom_range(2, 36));
      else r = 6'($urandom_range(0, 63));
      offer_word(v, r, 1'b0, "");
    end
    calm = 1'b0;

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (digits_due.size() != 0) @(posedge clk);
    // extra cycles so a stray word after the last expected one gets caught
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("integer_to_radix_digits: match");
    end else begin
      $display("integer_to_radix_digits: mismatch");
    end
    $finish;
  end

  // receiver: random stalls per word, one long hold to back the block up
  initial begin : result_sink
    int hold;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      hold = calm ? 0 : $urandom_range(0, 3);
      if (!long_hold_done && results_seen >= HOLD_AFTER) begin
        hold = LONG_HOLD;
        long_hold_done = 1'b1;
      end
      repeat (hold) begin
        @(negedge clk);
        out_ch.ready <= 1'b0;
      end
      @(negedge clk);
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid && out_ch.ready));
    end
  end

  // queue expectations for each taken input word, check each taken result word
  always @(posedge clk) begin : digit_check
    digit_word_t want;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        if (row_typed) begin
          if (row_text.len() == 0) begin
            want = '{digit_char: 7'd0, has_digit: 1'b0, last: 1'b1};
            digits_due.push_back(want);
          end else begin
            for (int i = 0; i < row_text.len(); i++) begin
              want.digit_char = 7'(row_text[i]);
              want.has_digit  = 1'b1;
              want.last       = (i == row_text.len() - 1);
              digits_due.push_back(want);
            end
          end
        end else begin
          predict_digits(in_ch.value, in_ch.radix);
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        results_seen++;
        if (digits_due.size() == 0) begin
          log_fault($sformatf("unexpected word: char %h has_digit %b last %b",
                              out_ch.digit_char, out_ch.has_digit, out_ch.last));
        end else begin
          want = digits_due.pop_front();
          if (out_ch.digit_char !== want.digit_char || out_ch.has_digit !== want.has_digit ||
              out_ch.last !== want.last)
            log_fault($sformatf(
              "word %0d: expected char %h has_digit %b last %b, got char %h has_digit %b last %b",
              results_seen, want.digit_char, want.has_digit, want.last,
              out_ch.digit_char, out_ch.has_digit, out_ch.last));
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("integer_to_radix_digits: mismatch");
      $finish;
    end
  end

endmodule
